FILE: sv/bmhpq_pkg.sv
// types, sizes and codes shared by the heap priority queue
package bmhpq_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KID_W    = IDX_W + 1;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] priority_req;
        logic [15:0]        payload;
    } t_item;

    typedef struct packed {
        logic               accepted;
        logic [7:0]         entry_count;
        logic               top_valid;
        logic signed [15:0] top_priority;
        logic [15:0]        top_payload;
    } t_result;

    typedef struct packed {
        logic signed [15:0] prio;
        logic [15:0]        tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_RD,
        S_RM_LD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

FILE: sv/binary_max_heap_priority_queue.sv
// max-priority queue kept as a binary heap in one synchronous memory
//
// An item (command, priority, payload) is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with o_result_valid, and
// busy drops in the cycle after it. The receiver cannot hold a result off. A
// query or a refused command goes straight from idle to the result state. An
// insert moves its item up the heap, and a remove loads the last entry into the
// root and moves it down, one heap level at a time; at most 7 levels are
// compared for an insert and 6 for a remove at 128 entries, since a remove
// leaves at most 127. Every level takes a registered memory read and then a
// compare and write back.
// The root is mirrored in a register so that every result can carry the top.
module binary_max_heap_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bmhpq_pkg::t_item  i_item,
    output logic              busy,
    output logic              o_result_valid,
    output bmhpq_pkg::t_result o_result
);

    localparam int IDX_W = bmhpq_pkg::IDX_W;
    localparam int CNT_W = bmhpq_pkg::CNT_W;
    localparam int KID_W = bmhpq_pkg::KID_W;

    localparam logic [1:0] CMD_INSERT_C = bmhpq_pkg::CMD_INSERT;
    localparam logic [1:0] CMD_REMOVE_C = bmhpq_pkg::CMD_REMOVE;
    localparam logic [1:0] CMD_QUERY_C  = bmhpq_pkg::CMD_QUERY;

    bmhpq_pkg::t_entry r_mem [bmhpq_pkg::CAPACITY];

    bmhpq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_pos;
    bmhpq_pkg::t_entry r_cur;
    bmhpq_pkg::t_entry r_top;
    logic              r_ok;
    bmhpq_pkg::t_entry r_rd0, r_rd1;

    logic              accept;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    bmhpq_pkg::t_entry mem_wdata;
    logic [IDX_W-1:0]  mem_raddr0, mem_raddr1;

    logic [IDX_W-1:0]  parent;
    logic [KID_W-1:0]  kid;
    logic [KID_W-1:0]  kid_r;
    logic [KID_W-1:0]  count_x;
    logic              kid_out;
    logic              right_pick;
    bmhpq_pkg::t_entry child;
    logic [IDX_W-1:0]  child_idx;
    logic              up_stop;
    logic              dn_stop;
    logic              ok_now;

    assign accept  = start && !busy;
    assign parent  = IDX_W'((r_pos - IDX_W'(1)) >> 1);
    assign kid     = {r_pos, 1'b1};
    assign kid_r   = kid + KID_W'(1);
    assign count_x = KID_W'(r_count);
    assign kid_out = (kid >= count_x);
    // right child only if it is live and strictly greater
    assign right_pick = (kid_r < count_x) && (r_rd0.prio < r_rd1.prio);
    assign child      = right_pick ? r_rd1 : r_rd0;
    assign child_idx  = right_pick ? kid_r[IDX_W-1:0] : kid[IDX_W-1:0];
    assign up_stop    = (r_rd0.prio > r_cur.prio);
    assign dn_stop    = (r_cur.prio >= child.prio);

    always_comb begin
        unique case (i_item.command)
            CMD_INSERT_C: ok_now = (r_count < CNT_W'(bmhpq_pkg::CAPACITY));
            CMD_REMOVE_C: ok_now = (r_count != '0);
            CMD_QUERY_C:  ok_now = (r_count != '0);
            default:      ok_now = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmhpq_pkg::S_IDLE: begin
                if (accept) begin
                    if (!ok_now || i_item.command == CMD_QUERY_C) begin
                        n_state = bmhpq_pkg::S_DONE;
                    end else if (i_item.command == CMD_INSERT_C) begin
                        n_state = bmhpq_pkg::S_UP_RD;
                    end else begin
                        n_state = bmhpq_pkg::S_RM_RD;
                    end
                end
            end
            bmhpq_pkg::S_UP_RD: begin
                n_state = (r_pos == '0) ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_UP_CMP;
            end
            bmhpq_pkg::S_UP_CMP: begin
                n_state = up_stop ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_UP_RD;
            end
            bmhpq_pkg::S_RM_RD: begin
                n_state = (r_count == '0) ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_RM_LD;
            end
            bmhpq_pkg::S_RM_LD: begin
                n_state = bmhpq_pkg::S_DN_RD;
            end
            bmhpq_pkg::S_DN_RD: begin
                n_state = kid_out ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_DN_CMP;
            end
            bmhpq_pkg::S_DN_CMP: begin
                n_state = dn_stop ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_DN_RD;
            end
            bmhpq_pkg::S_DONE: begin
                n_state = bmhpq_pkg::S_IDLE;
            end
            default: begin
                n_state = bmhpq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and memory controls
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = r_cur;
        mem_raddr0 = kid[IDX_W-1:0];
        mem_raddr1 = kid_r[IDX_W-1:0];
        busy       = (r_state != bmhpq_pkg::S_IDLE);
        o_result_valid = (r_state == bmhpq_pkg::S_DONE);
        unique case (r_state)
            bmhpq_pkg::S_UP_RD: begin
                mem_raddr0 = parent;
                mem_we     = (r_pos == '0);
            end
            bmhpq_pkg::S_UP_CMP: begin
                // hole moves up: parent drops into it unless it stays above
                mem_we    = 1'b1;
                mem_wdata = up_stop ? r_cur : r_rd0;
            end
            bmhpq_pkg::S_RM_RD: begin
                mem_raddr0 = r_count[IDX_W-1:0];
            end
            bmhpq_pkg::S_DN_RD: begin
                mem_we = kid_out;
            end
            bmhpq_pkg::S_DN_CMP: begin
                mem_we    = 1'b1;
                mem_wdata = dn_stop ? r_cur : child;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd0 <= r_mem[mem_raddr0];
        r_rd1 <= r_mem[mem_raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && mem_waddr == '0) begin
            r_top <= mem_wdata;
        end
        if (accept) begin
            r_cur.prio <= i_item.priority_req;
            r_cur.tag  <= i_item.payload;
            r_pos      <= r_count[IDX_W-1:0];
        end
        if (r_state == bmhpq_pkg::S_UP_CMP && !up_stop) begin
            r_pos <= parent;
        end
        if (r_state == bmhpq_pkg::S_RM_LD) begin
            r_cur <= r_rd0;
            r_pos <= '0;
        end
        if (r_state == bmhpq_pkg::S_DN_CMP && !dn_stop) begin
            r_pos <= child_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhpq_pkg::S_IDLE;
            r_count <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_ok <= ok_now;
                if (ok_now && i_item.command == CMD_INSERT_C) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (ok_now && i_item.command == CMD_REMOVE_C) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_result.accepted     = r_ok;
        o_result.entry_count  = 8'(r_count);
        o_result.top_valid    = (r_count != '0);
        o_result.top_priority = (r_count != '0) ? r_top.prio : '0;
        o_result.top_payload  = (r_count != '0) ? r_top.tag : '0;
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held more than one cycle");

    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy)
        else $error("busy not released after result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(bmhpq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.accepted) |-> $stable(r_count))
        else $error("refused item changed the count");

endmodule

FILE: verif/tb.sv
// self-checking testbench for the binary max-heap priority queue
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        bmhpq_pkg::t_item item;
        int unsigned      gap;
        bit               wait_drain;
    } t_queued_cmd;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    bmhpq_pkg::t_item   i_item = '0;
    logic               busy;
    logic               o_result_valid;
    bmhpq_pkg::t_result o_result;

    binary_max_heap_priority_queue i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // own copy of the heap, updated as each item is taken
    logic signed [15:0] shadow_prio [bmhpq_pkg::CAPACITY];
    logic [15:0]        shadow_tag  [bmhpq_pkg::CAPACITY];
    int unsigned        shadow_fill = 0;

    t_queued_cmd        cmd_backlog[$];
    bmhpq_pkg::t_result expected_results[$];
    int unsigned errors = 0;
    int unsigned gap_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned gen_fill = 0;

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic signed [15:0] tp;
        logic [15:0]        tt;
        tp = shadow_prio[a];
        tt = shadow_tag[a];
        shadow_prio[a] = shadow_prio[b];
        shadow_tag[a]  = shadow_tag[b];
        shadow_prio[b] = tp;
        shadow_tag[b]  = tt;
    endfunction

    function automatic bmhpq_pkg::t_result heap_apply(bmhpq_pkg::t_item it);
        bmhpq_pkg::t_result r;
        logic        ok;
        logic        done;
        int unsigned pos;
        int unsigned up;
        int unsigned kid;
        ok = 1'b0;
        if (it.command == bmhpq_pkg::CMD_INSERT) begin
            if (shadow_fill < bmhpq_pkg::CAPACITY) begin
                shadow_prio[shadow_fill] = it.priority_req;
                shadow_tag[shadow_fill]  = it.payload;
                pos  = shadow_fill;
                done = 1'b0;
                // climb while the parent is not strictly greater
                while (pos > 0 && !done) begin
                    up = (pos - 1) / 2;
                    if (shadow_prio[up] > shadow_prio[pos]) begin
                        done = 1'b1;
                    end else begin
                        swap_entries(up, pos);
                        pos = up;
                    end
                end
                shadow_fill++;
                ok = 1'b1;
            end
        end else if (it.command == bmhpq_pkg::CMD_REMOVE) begin
            if (shadow_fill > 0) begin
                shadow_fill--;
                shadow_prio[0] = shadow_prio[shadow_fill];
                shadow_tag[0]  = shadow_tag[shadow_fill];
                pos  = 0;
                done = 1'b0;
                while (!done) begin
                    kid = 2 * pos + 1;
                    if (kid >= shadow_fill) begin
                        done = 1'b1;
                    end else begin
                        // right child only when strictly greater
                        if (kid + 1 < shadow_fill && shadow_prio[kid] < shadow_prio[kid + 1])
                            kid++;
                        if (shadow_prio[pos] >= shadow_prio[kid]) begin
                            done = 1'b1;
                        end else begin
                            swap_entries(pos, kid);
                            pos = kid;
                        end
                    end
                end
                ok = 1'b1;
            end
        end else if (it.command == bmhpq_pkg::CMD_QUERY) begin
            ok = (shadow_fill > 0);
        end
        r.accepted    = ok;
        r.entry_count = shadow_fill[7:0];
        if (shadow_fill > 0) begin
            r.top_valid    = 1'b1;
            r.top_priority = shadow_prio[0];
            r.top_payload  = shadow_tag[0];
        end else begin
            r.top_valid    = 1'b0;
            r.top_priority = '0;
            r.top_payload  = '0;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 6)) - 3);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // the generator keeps its own fill count to steer the random phases
    task automatic queue_cmd(logic [1:0] cmd, logic signed [15:0] prio, logic [15:0] tag,
                             int unsigned gap, bit wait_drain);
        t_queued_cmd q;
        q.item.command      = cmd;
        q.item.priority_req = prio;
        q.item.payload      = tag;
        q.gap               = gap;
        q.wait_drain        = wait_drain;
        cmd_backlog.push_back(q);
        if (cmd == bmhpq_pkg::CMD_INSERT && gen_fill < bmhpq_pkg::CAPACITY)
            gen_fill++;
        else if (cmd == bmhpq_pkg::CMD_REMOVE && gen_fill > 0)
            gen_fill--;
    endtask

    function automatic int unsigned pick_gap(int unsigned n);
        // every fourth stretch of 32 items runs back to back
        if ((n / 32) % 4 == 1)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [1:0] weighted_cmd(logic [1:0] favored, logic [1:0] other);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r <= 6)
            return favored;
        else if (r == 7)
            return other;
        else if (r == 8)
            return bmhpq_pkg::CMD_QUERY;
        return bmhpq_pkg::CMD_RESERVED;
    endfunction

    // driver: offers the next item once its gap of free cycles is spent
    always @(posedge i_clk) begin : drive
        logic presenting;
        if (i_rst_n) begin
            presenting = start;
            if (start && !busy) begin
                expected_results.push_back(heap_apply(i_item));
                presenting = 1'b0;
                gap_left = (cmd_backlog.size() != 0) ? cmd_backlog[0].gap : 0;
            end else if (!presenting) begin
                if (gap_left > 0) begin
                    if (!busy)
                        gap_left--;
                end else if (cmd_backlog.size() != 0 &&
                             !(cmd_backlog[0].wait_drain && expected_results.size() != 0)) begin
                    i_item <= cmd_backlog[0].item;
                    cmd_backlog.pop_front();
                    presenting = 1'b1;
                end
            end
            start <= presenting;
        end
    end

    // monitor: every strobed result is matched against the oldest prediction
    always @(posedge i_clk) begin : monitor
        bmhpq_pkg::t_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result with no item pending: acc=%0b cnt=%0d vld=%0b %s",
                             o_result.accepted, o_result.entry_count, o_result.top_valid,
                             $sformatf("prio=%0d tag=%h",
                                       o_result.top_priority, o_result.top_payload));
            end else begin
                want = expected_results.pop_front();
                if (want.accepted !== o_result.accepted ||
                    want.entry_count !== o_result.entry_count ||
                    want.top_valid !== o_result.top_valid ||
                    want.top_priority !== o_result.top_priority ||
                    want.top_payload !== o_result.top_payload) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp acc=%0b cnt=%0d vld=%0b prio=%0d tag=%h,",
                                 want.accepted, want.entry_count, want.top_valid,
                                 want.top_priority, want.top_payload);
                        $display("          got acc=%0b cnt=%0d vld=%0b prio=%0d tag=%h",
                                 o_result.accepted, o_result.entry_count, o_result.top_valid,
                                 o_result.top_priority, o_result.top_payload);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", expected_results.size());
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned k;

        // directed: empty queue, extremes, equal priorities, unused code
        queue_cmd(bmhpq_pkg::CMD_QUERY,    16'sh0000, 16'h0000, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_REMOVE,   16'sh0000, 16'h0000, 2, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_RESERVED, 16'shffff, 16'hffff, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'sh7fff, 16'h0000, 1, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'sh8000, 16'hffff, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'sh7fff, 16'h1234, 3, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_QUERY,    16'sh0000, 16'h0000, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_RESERVED, 16'sh7fff, 16'hffff, 6, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'sh0000, 16'haaaa, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'shffff, 16'h5555, 4, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'sh0005, 16'h0001, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'sh0005, 16'h0002, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_INSERT,   16'sh0005, 16'h0003, 5, 1'b0);
        for (k = 0; k < 8; k++)
            queue_cmd(bmhpq_pkg::CMD_REMOVE, 16'sh0000, 16'h0000, $urandom_range(0, 6), 1'b0);
        queue_cmd(bmhpq_pkg::CMD_QUERY,    16'sh0000, 16'h0000, 0, 1'b0);
        queue_cmd(bmhpq_pkg::CMD_RESERVED, 16'sh0000, 16'h0000, 0, 1'b0);

        // fill to capacity, then push against the full store
        n = 0;
        queue_cmd(bmhpq_pkg::CMD_INSERT, rand_prio(), 16'($urandom), 0, 1'b1);
        while (gen_fill < bmhpq_pkg::CAPACITY) begin
            queue_cmd(weighted_cmd(bmhpq_pkg::CMD_INSERT, bmhpq_pkg::CMD_REMOVE), rand_prio(),
                      16'($urandom), pick_gap(n), 1'b0);
            n++;
        end
        for (k = 0; k < 6; k++)
            queue_cmd(bmhpq_pkg::CMD_INSERT, rand_prio(), 16'($urandom),
                      $urandom_range(0, 6), 1'b0);
        queue_cmd(bmhpq_pkg::CMD_QUERY, rand_prio(), 16'($urandom), 0, 1'b0);

        // drain to empty, then push against the empty store
        n = 0;
        queue_cmd(bmhpq_pkg::CMD_REMOVE, rand_prio(), 16'($urandom), 0, 1'b1);
        while (gen_fill > 0) begin
            queue_cmd(weighted_cmd(bmhpq_pkg::CMD_REMOVE, bmhpq_pkg::CMD_INSERT), rand_prio(),
                      16'($urandom), pick_gap(n), 1'b0);
            n++;
        end
        for (k = 0; k < 3; k++)
            queue_cmd(bmhpq_pkg::CMD_REMOVE, rand_prio(), 16'($urandom),
                      $urandom_range(0, 6), 1'b0);
        queue_cmd(bmhpq_pkg::CMD_QUERY, rand_prio(), 16'($urandom), 0, 1'b0);

        // mixed traffic with a pause for all results midway
        for (n = 0; n < 220; n++)
            queue_cmd(weighted_cmd(($urandom_range(0, 1) == 0) ? bmhpq_pkg::CMD_INSERT
                                                               : bmhpq_pkg::CMD_REMOVE,
                                   ($urandom_range(0, 1) == 0) ? bmhpq_pkg::CMD_INSERT
                                                               : bmhpq_pkg::CMD_REMOVE),
                      rand_prio(), 16'($urandom), pick_gap(n), n == 110);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || start || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0d predicted results never arrived", expected_results.size());
            errors += expected_results.size();
        end
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
